// File: hdl/kstk_pkg.sv
// Package for the k_stacks_in_one_memory block: field widths, codes and defaults.
// Used by kstk_fill, k_stacks_in_one_memory and kstk_chk; depends on nothing.
package kstk_pkg;

    // Fixed field widths of the item and result
    localparam int SEL_W      = 3;
    localparam int CMD_W      = 1;
    localparam int STATUS_W   = 2;

    // Configuration register widths
    localparam int STK_CFG_W  = 4;
    localparam int SLOT_W     = 9;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_IDX_W  = 1;

    // Defaults for the top-level parameters
    localparam int MAX_STACKS_DEF = 8;
    localparam int MEM_DEPTH_DEF  = 256;
    localparam int DATA_WIDTH_DEF = 32;

    // Register reset values
    localparam logic [STK_CFG_W-1:0] STACKS_RST = STK_CFG_W'(3);
    localparam logic [SLOT_W-1:0]    SLOTS_RST  = SLOT_W'(32);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STACKS_IN_USE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOTS_PER_STACK = 1'b1;

    // Commands
    localparam logic [CMD_W-1:0] CMD_PUSH = 1'b0;
    localparam logic [CMD_W-1:0] CMD_POP  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_BAD_STACK = 2'd3
    } status_t;

    // Outcome of one item, from the bookkeeping to the sequencer
    typedef struct packed {
        status_t            status;
        logic [SEL_W-1:0]   landed;
        logic               push_ok;
        logic               pop_ok;
        logic               all_empty;
    } dec_t;

endpackage

// File: hdl/kstk_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module kstk_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hdl/kstk_fill.sv
// Stack bookkeeping: configuration registers, fill counts, used count and
// the push/pop decision with spill search and address. Depends on kstk_pkg.
module kstk_fill #(
    parameter int MAX_STACKS = kstk_pkg::MAX_STACKS_DEF,
    parameter int MEM_DEPTH  = kstk_pkg::MEM_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [kstk_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [kstk_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              commit,
    input  logic [kstk_pkg::CMD_W-1:0]        cmd,
    input  logic [kstk_pkg::SEL_W-1:0]        stack_sel,
    output kstk_pkg::dec_t                    dec,
    output logic [$clog2(MEM_DEPTH)-1:0]      addr
);

    import kstk_pkg::*;

    // Only stacks reachable by a 3-bit selector get a counter
    localparam int NSTK     = (MAX_STACKS < (1 << SEL_W)) ? MAX_STACKS : (1 << SEL_W);
    localparam int AW       = $clog2(MEM_DEPTH);
    localparam int UW       = $clog2(MEM_DEPTH + 1);
    localparam int NCODES   = 1 << STK_CFG_W;
    localparam int SLOT_MAX = (1 << SLOT_W) - 1;
    localparam int SUM_W    = SEL_W + SLOT_W + 1;

    logic [STK_CFG_W-1:0] stacks_reg;
    logic [SLOT_W-1:0]    slots_reg;
    logic [SLOT_W-1:0]    fill_reg [NSTK];
    logic [UW-1:0]        used_reg;
    logic [UW-1:0]        used_next;

    logic [SLOT_W-1:0]    lim_tab [NCODES];
    logic [STK_CFG_W-1:0] ns;
    logic [SLOT_W-1:0]    slots_min1;
    logic [SLOT_W-1:0]    slots;
    logic [NSTK-1:0]      room;
    logic                 any_room;
    logic                 room_sel;
    logic [SEL_W-1:0]     first_room;
    logic [SEL_W-1:0]     idx;
    logic [SLOT_W-1:0]    fill_idx;
    logic [SLOT_W-1:0]    off;
    logic [SUM_W-1:0]     base;
    logic [SUM_W-1:0]     sum;
    logic                 bad;
    logic                 is_push;
    logic                 push_ok;
    logic                 pop_ok;
    status_t              status;

    // Per-count slot limit MEM_DEPTH / stacks, worked out at elaboration
    for (genvar g = 0; g < NCODES; g++)
    begin : g_lim
        localparam int DIV  = (g == 0) ? 1 : g;
        localparam int LIM  = MEM_DEPTH / DIV;
        localparam int LIMC = (LIM > SLOT_MAX) ? SLOT_MAX : LIM;
        assign lim_tab[g] = SLOT_W'(LIMC);
    end

    // Effective stack count and partition size
    always_comb
    begin
        priority if (stacks_reg == '0)
            ns = STK_CFG_W'(1);
        else if (32'(stacks_reg) > 32'(MAX_STACKS))
            ns = STK_CFG_W'(MAX_STACKS);
        else
            ns = stacks_reg;
    end

    assign slots_min1 = (slots_reg == '0) ? SLOT_W'(1) : slots_reg;
    assign slots      = (slots_min1 > lim_tab[ns]) ? lim_tab[ns] : slots_min1;

    // Room per stack and lowest stack with room
    always_comb
    begin
        room       = '0;
        room_sel   = 1'b0;
        first_room = '0;
        for (int i = 0; i < NSTK; i++)
        begin
            room[i] = (fill_reg[i] < slots) && (STK_CFG_W'(i) < ns);
            if (SEL_W'(i) == stack_sel)
                room_sel = room[i];
        end
        for (int i = NSTK - 1; i >= 0; i--)
        begin
            if (room[i])
                first_room = SEL_W'(i);
        end
    end

    // Fill of the chosen stack
    always_comb
    begin
        fill_idx = '0;
        for (int i = 0; i < NSTK; i++)
        begin
            if (SEL_W'(i) == idx)
                fill_idx = fill_reg[i];
        end
    end

    assign is_push  = (cmd == CMD_PUSH);
    assign any_room = |room;
    assign bad      = (STK_CFG_W'(stack_sel) >= ns);
    assign idx      = (is_push && !room_sel) ? first_room : stack_sel;

    always_comb
    begin
        priority if (bad)
            status = ST_BAD_STACK;
        else if (is_push && !any_room)
            status = ST_FULL;
        else if (!is_push && fill_idx == '0)
            status = ST_UNDERFLOW;
        else
            status = ST_OK;
    end

    assign push_ok = (status == ST_OK) && is_push;
    assign pop_ok  = (status == ST_OK) && !is_push;

    // Entry address: partition base plus offset in the partition
    assign off  = is_push ? fill_idx : fill_idx - SLOT_W'(1);
    assign base = SUM_W'(idx) * SUM_W'(slots);
    assign sum  = base + SUM_W'(off);
    assign addr = AW'(sum);

    always_comb
    begin
        used_next = used_reg;
        if (push_ok)
            used_next = used_reg + UW'(1);
        else if (pop_ok)
            used_next = used_reg - UW'(1);
    end

    assign dec.status    = status;
    assign dec.landed    = (status == ST_OK) ? idx : stack_sel;
    assign dec.push_ok   = push_ok;
    assign dec.pop_ok    = pop_ok;
    assign dec.all_empty = (used_next == '0);

    // A configuration write empties every stack
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stacks_reg <= STACKS_RST;
            slots_reg  <= SLOTS_RST;
            used_reg   <= '0;
            for (int i = 0; i < NSTK; i++)
                fill_reg[i] <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_STACKS_IN_USE:   stacks_reg <= STK_CFG_W'(cfg_data);
                REG_SLOTS_PER_STACK: slots_reg  <= cfg_data;
                default:             ;
            endcase
            used_reg <= '0;
            for (int i = 0; i < NSTK; i++)
                fill_reg[i] <= '0;
        end
        else if (commit)
        begin
            used_reg <= used_next;
            for (int i = 0; i < NSTK; i++)
            begin
                if (SEL_W'(i) == idx && push_ok)
                    fill_reg[i] <= fill_reg[i] + SLOT_W'(1);
                else if (SEL_W'(i) == idx && pop_ok)
                    fill_reg[i] <= fill_reg[i] - SLOT_W'(1);
            end
        end
    end

endmodule

// File: hdl/k_stacks_in_one_memory.sv
// Top level of the k_stacks_in_one_memory block: sequencer, entry RAM and result register.
// Depends on kstk_pkg, kstk_ram and kstk_fill.
//
// Several LIFO stacks share one entry RAM of MEM_DEPTH words, cut into equal
// partitions of slots_per_stack entries. Each item is a push or a pop on one
// stack; each gives exactly one result with status, the stack it landed on,
// the popped value and an all-empty flag. A push to a full stack spills into
// the lowest-numbered stack with room. When the result side is free, an
// item goes as follows: in the accept cycle the decision is made, fill
// counts are updated and the RAM is written (push) or read (pop); the next
// cycle picks up the registered RAM read data and loads the result
// register. in_stall is high in the cycle after an accept and for as long
// as a finished result cannot get into the result register; a result
// waiting in the output register does not block the next item. The entry
// RAM needs no clearing pass after reset: only entries written by a push
// are ever read. Configuration writes empty all stacks and are expected
// only while the block is idle.
module k_stacks_in_one_memory #(
    parameter int MAX_STACKS = kstk_pkg::MAX_STACKS_DEF,
    parameter int MEM_DEPTH  = kstk_pkg::MEM_DEPTH_DEF,
    parameter int DATA_WIDTH = kstk_pkg::DATA_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration
    input  logic                             cfg_we,
    input  logic [kstk_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [kstk_pkg::CFG_DATA_W-1:0]  cfg_data,
    // item channel
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [kstk_pkg::CMD_W-1:0]       cmd,
    input  logic [kstk_pkg::SEL_W-1:0]       stack_sel,
    input  logic signed [DATA_WIDTH-1:0]     push_value,
    // result channel
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [kstk_pkg::STATUS_W-1:0]    status,
    output logic [kstk_pkg::SEL_W-1:0]       landed_stack,
    output logic signed [DATA_WIDTH-1:0]     popped_value,
    output logic                             all_empty
);

    import kstk_pkg::*;

    localparam int AW = $clog2(MEM_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_HOLD
    } state_t;

    state_t state_reg, state_next;

    // Decision of the item in flight
    dec_t             dec;
    logic [AW-1:0]    addr;
    dec_t             ex_reg;
    logic [AW-1:0]    ex_addr_reg;

    // Result parked while the output register is busy
    dec_t                    hold_reg, hold_next;
    logic [DATA_WIDTH-1:0]   hold_value_reg, hold_value_next;

    // Output register
    logic                    out_valid_reg, out_valid_next;
    status_t                 status_reg, status_next;
    logic [SEL_W-1:0]        landed_reg, landed_next;
    logic [DATA_WIDTH-1:0]   value_reg, value_next;
    logic                    empty_reg, empty_next;

    logic                    accept;
    logic                    out_free;
    logic [DATA_WIDTH-1:0]   ex_value;

    // RAM ports
    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [DATA_WIDTH-1:0]   ram_wdata;
    logic                    ram_re;
    logic [DATA_WIDTH-1:0]   ram_rdata;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    kstk_fill #(
        .MAX_STACKS (MAX_STACKS),
        .MEM_DEPTH  (MEM_DEPTH)
    ) u_fill (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .commit    (accept),
        .cmd       (cmd),
        .stack_sel (stack_sel),
        .dec       (dec),
        .addr      (addr)
    );

    // Push writes in the accept cycle; a pop reads then and clears the
    // vacated entry in the following cycle. The two never collide because
    // no item is taken while the clear is written.
    assign ram_we    = (accept && dec.push_ok) || (state_reg == S_EXEC && ex_reg.pop_ok);
    assign ram_waddr = (state_reg == S_EXEC) ? ex_addr_reg : addr;
    assign ram_wdata = (state_reg == S_EXEC) ? '0 : push_value;
    assign ram_re    = accept && dec.pop_ok;

    kstk_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (MEM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (addr),
        .rdata (ram_rdata)
    );

    assign ex_value = ex_reg.pop_ok ? ram_rdata : '0;

    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg && out_stall;
        status_next     = status_reg;
        landed_next     = landed_reg;
        value_next      = value_reg;
        empty_next      = empty_reg;
        hold_next       = hold_reg;
        hold_value_next = hold_value_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = ex_reg.status;
                    landed_next    = ex_reg.landed;
                    value_next     = ex_value;
                    empty_next     = ex_reg.all_empty;
                    state_next     = S_IDLE;
                end
                else
                begin
                    hold_next       = ex_reg;
                    hold_value_next = ex_value;
                    state_next      = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = hold_reg.status;
                    landed_next    = hold_reg.landed;
                    value_next     = hold_value_reg;
                    empty_next     = hold_reg.all_empty;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            status_reg     <= status_next;
            landed_reg     <= landed_next;
            value_reg      <= value_next;
            empty_reg      <= empty_next;
            hold_reg       <= hold_next;
            hold_value_reg <= hold_value_next;
            if (accept)
            begin
                ex_reg      <= dec;
                ex_addr_reg <= addr;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign landed_stack = landed_reg;
    assign popped_value = value_reg;
    assign all_empty    = empty_reg;

endmodule

// File: hdl/kstk_chk.sv
// Port-level checker for k_stacks_in_one_memory, bound to the top level.
// Depends on kstk_pkg.
module kstk_chk #(
    parameter int DATA_WIDTH = kstk_pkg::DATA_WIDTH_DEF
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_stall,
    input logic                             out_valid,
    input logic                             out_stall,
    input logic [kstk_pkg::STATUS_W-1:0]    status,
    input logic [kstk_pkg::SEL_W-1:0]       landed_stack,
    input logic signed [DATA_WIDTH-1:0]     popped_value,
    input logic                             all_empty
);

    import kstk_pkg::*;

    logic in_acc;
    assign in_acc = in_valid && !in_stall;

    // Only a successful pop carries a value
    a_value_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> (popped_value == '0))
        else $error("popped value on a failed item");

    // Full memory cannot be empty
    a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_FULL) |-> !all_empty)
        else $error("memory full reported with all stacks empty");

    // One item at a time: busy the cycle after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> in_stall)
        else $error("item accepted while the previous one is in work");

    // Result is registered straight after the execute step when the output is free
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc ##1 !(out_valid && out_stall) |=> out_valid)
        else $error("result missing two cycles after accept");

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status)
            && $stable(landed_stack) && $stable(popped_value) && $stable(all_empty))
        else $error("stalled result changed");

endmodule

bind k_stacks_in_one_memory kstk_chk #(.DATA_WIDTH(DATA_WIDTH)) u_kstk_chk (.*);
